### src/nlpi_pkg.sv
// Package for the nonlinear PI valve controller.
// Holds the shared constants, the datapath command codes and the command and status structs.
package nlpi_pkg;

  localparam int ErrLimit     = 1200;
  localparam int ErrTolerance = 5;
  localparam int BlockTicks   = 8;
  localparam int CreditExpiry = 20;
  localparam int SumScale     = 3276800;
  localparam int DivBits      = 22;
  localparam int RecipWeight  = 3277;
  localparam int RecipShift   = 16;

  localparam logic [2:0] RegPropGain  = 3'd0;
  localparam logic [2:0] RegCubicGain = 3'd1;
  localparam logic [2:0] RegIntGain   = 3'd2;
  localparam logic [2:0] RegValveUp   = 3'd3;
  localparam logic [2:0] RegValveLow  = 3'd4;
  localparam logic [2:0] RegValveMid  = 3'd5;
  localparam logic [2:0] RegRoundHyst = 3'd6;
  localparam logic [2:0] RegCreditMax = 3'd7;

  typedef enum logic [3:0] {
    OpNone  = 4'd0,
    OpLoad  = 4'd1,
    OpQuot  = 4'd2,
    OpUpd   = 4'd3,
    OpDiv   = 4'd4,
    OpClamp = 4'd5,
    OpMul1  = 4'd6,
    OpMul2  = 4'd7,
    OpMul3  = 4'd8,
    OpMul4  = 4'd9,
    OpSum   = 4'd10,
    OpOut   = 4'd11
  } nlpi_op_e;

  typedef struct packed {
    nlpi_op_e op;
    logic     div_first;
  } nlpi_cmd_t;

  typedef struct packed {
    logic out_valid;
  } nlpi_status_t;

endpackage

### src/nlpi_ctrl.sv
// Sequencer of the nonlinear PI valve controller.
// Steps the datapath through one item; uses nlpi_pkg.
module nlpi_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  input  nlpi_pkg::nlpi_status_t status_i,
  output nlpi_pkg::nlpi_cmd_t    cmd_o
);
  import nlpi_pkg::*;

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StQuot  = 11'b00000000010,
    StUpd   = 11'b00000000100,
    StDiv   = 11'b00000001000,
    StClamp = 11'b00000010000,
    StMul1  = 11'b00000100000,
    StMul2  = 11'b00001000000,
    StMul3  = 11'b00010000000,
    StMul4  = 11'b00100000000,
    StSum   = 11'b01000000000,
    StOut   = 11'b10000000000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '{op: OpNone, div_first: 1'b0};
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.op = OpLoad;
          state_d  = StQuot;
        end
      end
      StQuot: begin
        cmd_o.op = OpQuot;
        state_d  = StUpd;
      end
      StUpd: begin
        cmd_o.op = OpUpd;
        cnt_d    = '0;
        state_d  = StDiv;
      end
      StDiv: begin
        cmd_o.op        = OpDiv;
        cmd_o.div_first = (cnt_q == '0);
        cnt_d           = cnt_q + 5'd1;
        if (cnt_q == 5'(DivBits - 1)) begin
          state_d = StClamp;
        end
      end
      StClamp: begin
        cmd_o.op = OpClamp;
        state_d  = StMul1;
      end
      StMul1: begin
        cmd_o.op = OpMul1;
        state_d  = StMul2;
      end
      StMul2: begin
        cmd_o.op = OpMul2;
        state_d  = StMul3;
      end
      StMul3: begin
        cmd_o.op = OpMul3;
        state_d  = StMul4;
      end
      StMul4: begin
        cmd_o.op = OpMul4;
        state_d  = StSum;
      end
      StSum: begin
        cmd_o.op = OpSum;
        state_d  = StOut;
      end
      StOut: begin
        if (!status_i.out_valid || out_ready_i) begin
          cmd_o.op = OpOut;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### src/nlpi_datapath.sv
// Datapath of the nonlinear PI valve controller: registers, integrator state,
// shared multiply steps, the limit divider and the output register; uses nlpi_pkg.
module nlpi_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  input  logic [39:0]           in_data_i,
  input  logic                  in_flag_i,
  input  nlpi_pkg::nlpi_cmd_t    cmd_i,
  output nlpi_pkg::nlpi_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_data_o
);
  import nlpi_pkg::*;

  logic [7:0] prop_q, cubic_q, igain_q, vup_q, vlow_q, vmid_q;
  logic [6:0] hyst_q, cmax_q;

  logic signed [31:0] es_q, es_d;
  logic               pneg_q, pneg_d;
  logic [10:0]        pae_q, pae_d, p2ae_q, p2ae_d;
  logic signed [8:0]  cred_q, cred_d;
  logic [7:0]         ctim_q, ctim_d, blk_q, blk_d;
  logic [15:0]        cae_q, cae_d;
  logic signed [31:0] ces_q, ces_d;

  logic signed [11:0] e_q;
  logic [10:0]        ae_q;
  logic               neg_q, chg_q;
  logic [7:0]         old_q;
  logic [5:0]         quo_q;
  logic [21:0]        dvd_q, lim_q;
  logic [8:0]         rem_q;
  logic [20:0]        sq_q;
  logic [21:0]        cub_q;
  logic signed [39:0] p1_q, p2_q, pi_q;
  logic               ov_q;
  logic [7:0]         od_q;

  // Input difference and clamp.
  logic signed [16:0] diff;
  logic signed [11:0] e_c;
  always_comb begin
    diff = 17'(signed'(in_data_i[15:0])) - 17'(signed'(in_data_i[31:16]));
    if (diff > 17'sd1200)       e_c = 12'sd1200;
    else if (diff < -17'sd1200) e_c = -12'sd1200;
    else                        e_c = diff[11:0];
  end

  // Integrator state update.
  logic [21:0]        qprod;
  logic signed [33:0] isum;
  logic signed [31:0] es_int;
  logic               room;
  logic [17:0]        thr;
  always_comb begin
    qprod = 22'(ae_q) * 22'(RecipWeight);
    isum  = 34'(es_q) + 34'(signed'({e_q, 3'b000}));
    if (isum > 34'sh07fffffff)       es_int = 32'sh7fffffff;
    else if (isum < -34'sh080000000) es_int = 32'sh80000000;
    else                             es_int = isum[31:0];
    room = neg_q ? (old_q > vlow_q) : (old_q < vup_q);
    es_d   = es_q;
    pneg_d = pneg_q;
    pae_d  = pae_q;
    p2ae_d = p2ae_q;
    cred_d = cred_q;
    ctim_d = ctim_q;
    blk_d  = blk_q;
    cae_d  = cae_q;
    ces_d  = ces_q;
    thr    = (18'(cae_q) * 18'd3) >> 2;
    if (chg_q) begin
      cred_d = 9'(cmax_q);
      ctim_d = 8'(CreditExpiry);
      blk_d  = 8'(BlockTicks);
      if (18'(pae_q) >= thr && pae_q > 11'(2 * ErrTolerance)) begin
        es_d = ces_q;
      end
      cae_d = 16'(ae_q);
      ces_d = es_d;
    end else begin
      if (blk_q == '0) begin
        if (ctim_q != '0) ctim_d = ctim_q - 8'd1;
        else              cred_d = '0;
        if (room) begin
          if (pneg_q != neg_q || (ae_q == p2ae_q && ae_q <= 11'(ErrTolerance))) begin
            cred_d = 9'(cmax_q);
            ctim_d = 8'(CreditExpiry);
            es_d   = es_int;
          end else if (cred_d > 9'sd0 && ae_q >= p2ae_q) begin
            cred_d = cred_d - 9'(quo_q) - 9'sd1;
            if (cred_d < -9'sd128) cred_d = -9'sd128;
            es_d = es_int;
          end
        end
        if (cred_d <= 9'sd0) begin
          if (18'(ae_q) >= thr && ae_q > 11'(2 * ErrTolerance)) begin
            es_d = ces_q;
          end
          cae_d = 16'hffff;
        end
      end else begin
        blk_d = blk_q - 8'd1;
      end
      p2ae_d = pae_q;
      pae_d  = ae_q;
      pneg_d = neg_q;
    end
  end

  // Restoring divider step for the sum limit.
  logic [21:0] dvd_cur, lim_cur;
  logic [8:0]  rem_cur, rem_sh;
  always_comb begin
    dvd_cur = cmd_i.div_first ? 22'(SumScale) : dvd_q;
    rem_cur = cmd_i.div_first ? '0 : rem_q;
    lim_cur = cmd_i.div_first ? '0 : lim_q;
    rem_sh  = {rem_cur[7:0], dvd_cur[21]};
  end

  // Output scaling and rounding.
  logic signed [31:0] pis;
  logic [17:0]        pr;
  logic [7:0]         res;
  always_comb begin
    pis = pi_q[39:8];
    pr  = 18'(pis[16:0]) + 18'd128;
    res = vlow_q;
    if (pi_q < 40'sd0) begin
      res = vlow_q;
    end else if (pis > 32'(signed'({1'b0, vup_q, 8'h00}))) begin
      res = vup_q;
    end else begin
      if (pis[16:8] >= 9'(old_q)) pr = pr - 18'(hyst_q);
      else                         pr = pr + 18'(hyst_q);
      res = (pr[15:8] < vlow_q) ? vlow_q : pr[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= 8'd13;
      cubic_q <= 8'd23;
      igain_q <= 8'd8;
      vup_q   <= 8'd80;
      vlow_q  <= 8'd0;
      vmid_q  <= 8'd30;
      hyst_q  <= 7'd24;
      cmax_q  <= 7'd60;
      es_q    <= '0;
      pneg_q  <= 1'b0;
      pae_q   <= '0;
      p2ae_q  <= '0;
      cred_q  <= '0;
      ctim_q  <= '0;
      blk_q   <= '0;
      cae_q   <= '0;
      ces_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegPropGain:  prop_q  <= cfg_data_i;
          RegCubicGain: cubic_q <= cfg_data_i;
          RegIntGain:   igain_q <= cfg_data_i;
          RegValveUp:   vup_q   <= cfg_data_i;
          RegValveLow:  vlow_q  <= cfg_data_i;
          RegValveMid:  vmid_q  <= cfg_data_i;
          RegRoundHyst: hyst_q  <= cfg_data_i[6:0];
          RegCreditMax: cmax_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OpUpd) begin
        es_q   <= es_d;
        pneg_q <= pneg_d;
        pae_q  <= pae_d;
        p2ae_q <= p2ae_d;
        cred_q <= cred_d;
        ctim_q <= ctim_d;
        blk_q  <= blk_d;
        cae_q  <= cae_d;
        ces_q  <= ces_d;
      end
      if (cmd_i.op == OpClamp && igain_q != '0) begin
        if (es_q > 32'(signed'({1'b0, lim_q}))) begin
          es_q <= 32'(signed'({1'b0, lim_q}));
        end else if (es_q < -32'(signed'({1'b0, lim_q}))) begin
          es_q <= -32'(signed'({1'b0, lim_q}));
        end
      end
      if (cmd_i.op == OpOut) ov_q <= 1'b1;
      else if (out_ready_i)  ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpLoad: begin
        e_q   <= e_c;
        ae_q  <= e_c[11] ? 11'(-e_c) : e_c[10:0];
        neg_q <= e_c[11];
        old_q <= in_data_i[39:32];
        chg_q <= in_flag_i;
      end
      OpQuot: quo_q <= qprod[RecipShift+5:RecipShift];
      OpDiv: begin
        dvd_q <= {dvd_cur[20:0], 1'b0};
        if (rem_sh >= 9'(igain_q)) begin
          rem_q <= rem_sh - 9'(igain_q);
          lim_q <= {lim_cur[20:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          lim_q <= {lim_cur[20:0], 1'b0};
        end
      end
      OpMul1: sq_q <= 21'(24'(e_q) * 24'(e_q));
      OpMul2: cub_q <= 22'((29'(sq_q) * 29'(cubic_q)) >> 8) + 22'({prop_q, 8'h00});
      OpMul3: p1_q <= 40'(signed'({1'b0, cub_q})) * 40'(e_q);
      OpMul4: p2_q <= 40'(signed'({1'b0, igain_q})) * 40'(es_q);
      OpSum:  pi_q <= p1_q + p2_q + 40'(signed'({1'b0, vmid_q, 16'h0000}));
      OpOut:  od_q <= res;
      default: ;
    endcase
  end

  assign status_o.out_valid = ov_q;
  assign out_valid_o        = ov_q;
  assign out_data_o         = od_q;

endmodule

### src/nonlinear_pi_valve_controller.sv
// Top level of the nonlinear PI valve controller.
// Joins the sequencer nlpi_ctrl and the datapath nlpi_datapath; uses nlpi_pkg.
//
// One input item per control tick on the slave stream: tdata carries the set
// point, the measured temperature and the previous valve position, tuser the
// target-changed flag. Each item gives exactly one result item, the new valve
// position, on the master stream.
// The result is offered after these steps in order: the quotient, the state
// update, the bit-serial divider that forms the integrator limit, the sum
// clamp, four multiply steps, the final sum, and rounding into the output
// register.
// A new item is accepted only while the sequencer is idle, from the cycle
// after the result is loaded, so no item is taken before the last is finished.
// The output register holds a finished result while the receiver stalls; the
// next item is still accepted and is finished up to its final step.
// Reset clears the controller state and loads the register defaults. The
// configuration port writes one register per cycle, with no read-back.
module nonlinear_pi_valve_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // set_point [15:0], process_value [31:16], prev_valve [39:32]
  input  logic [39:0] s_axis_tdata,
  // target_changed [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // valve [7:0]
  output logic [7:0]  m_axis_tdata
);
  import nlpi_pkg::*;

  nlpi_cmd_t    cmd;
  nlpi_status_t status;

  nlpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nlpi_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_flag_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### dv/nonlinear_pi_valve_controller_test.sv
// Self-checking testbench for the nonlinear PI valve controller.
// Drives control ticks on the slave stream, predicts each valve position with
// its own controller model, and compares results; depends on nlpi_pkg.
module nonlinear_pi_valve_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nlpi_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  nonlinear_pi_valve_controller DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  typedef struct {
    logic signed [15:0] sp;
    logic signed [15:0] pv;
    logic [7:0]         old;
    logic               chg;
    int                 want;   // -1: use the prediction
  } tick_t;

  // controller settings
  int unsigned kp, kc, ki, vup, vlow, vmid, hyst, cmax;
  // controller state
  longint esum, chg_esum;
  bit     was_neg;
  int unsigned abs1, abs2, timer, block_cnt, chg_abs;
  int     credit;

  logic [7:0] valve_q[$];
  int errors = 0, ticks = 0, results = 0;
  int idle_pct = 0, stall_pct = 0;

  task automatic report(input string what, input int got, input int exp_v);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp_v, $time);
  endtask

  function automatic void reset_model();
    kp = 13; kc = 23; ki = 8; vup = 80; vlow = 0; vmid = 30; hyst = 24; cmax = 60;
    esum = 0; chg_esum = 0; was_neg = 0; abs1 = 0; abs2 = 0; timer = 0;
    block_cnt = 0; chg_abs = 0; credit = 0;
  endfunction

  function automatic void set_reg(input logic [2:0] idx, input int unsigned v);
    case (idx)
      RegPropGain:  kp = v & 255;
      RegCubicGain: kc = v & 255;
      RegIntGain:   ki = v & 255;
      RegValveUp:   vup = v & 255;
      RegValveLow:  vlow = v & 255;
      RegValveMid:  vmid = v & 255;
      RegRoundHyst: hyst = v & 127;
      default:      cmax = v & 127;
    endcase
  endfunction

  function automatic void revert_if_stuck(input int unsigned a);
    if (a >= ((chg_abs * 3) >> 2) && a > ErrTolerance * 2) esum = chg_esum;
    chg_abs = 'hffff;
  endfunction

  function automatic void accumulate(input int e);
    esum = esum + e * 8;
    if (esum > 64'sd2147483647) esum = 64'sd2147483647;
    if (esum < -64'sd2147483648) esum = -64'sd2147483648;
  endfunction

  function automatic logic [7:0] next_valve(input tick_t t);
    int e, lim;
    int unsigned ae, res, p;
    bit neg, room, gt;
    longint pi;
    e = int'(t.sp) - int'(t.pv);
    if (e > ErrLimit) e = ErrLimit;
    if (e < -ErrLimit) e = -ErrLimit;
    ae = e < 0 ? -e : e;
    neg = e < 0;
    if (t.chg) begin
      credit = cmax; timer = CreditExpiry; block_cnt = BlockTicks;
      revert_if_stuck(abs1);
      chg_abs = ae; chg_esum = esum;
    end else begin
      if (block_cnt == 0) begin
        if (timer > 0) timer--;
        else credit = 0;
        room = (e >= 0) ? (t.old < vup) : (t.old > vlow);
        if (room) begin
          if (was_neg != neg || (ae == abs2 && ae <= ErrTolerance)) begin
            credit = cmax; timer = CreditExpiry;
            accumulate(e);
          end else if (credit > 0 && ae >= abs2) begin
            credit -= ae / 20 + 1;
            if (credit < -128) credit = -128;
            accumulate(e);
          end
        end
        if (credit <= 0) revert_if_stuck(ae);
      end else block_cnt--;
      abs2 = abs1; abs1 = ae; was_neg = neg;
    end
    if (ki > 0) begin
      lim = SumScale / ki;
      if (esum > lim) esum = lim;
      else if (esum < -lim) esum = -lim;
    end
    pi = (longint'(e) * longint'(e) * longint'(kc)) >>> 8;
    pi = (pi + longint'(kp << 8)) * longint'(e) + longint'(ki) * esum
         + longint'(vmid) * 64'sd65536;
    if (pi < 0) res = vlow;
    else begin
      pi = pi >>> 8;
      if (pi > vup * 256) res = vup;
      else begin
        p = pi;
        gt = (p >> 8) >= t.old;
        p += 128;
        if (gt) p -= hyst; else p += hyst;
        p >>= 8;
        res = p < vlow ? vlow : p;
      end
    end
    return res[7:0];
  endfunction

  task automatic write_reg(input logic [2:0] idx, input int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v[7:0];
    @(posedge clk_i);
    set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (valve_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic send(input tick_t t);
    logic [7:0] v;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {t.old, t.pv, t.sp};
    s_axis_tuser <= t.chg;
    do @(posedge clk_i); while (!s_axis_tready);
    v = next_valve(t);
    if (t.want >= 0 && v != t.want) report("predictor table", v, t.want);
    valve_q.push_back(v);
    ticks++;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  always @(negedge clk_i) m_axis_tready <= $urandom_range(99) >= stall_pct;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      results++;
      if (valve_q.size() == 0) report("unexpected valve", m_axis_tdata, -1);
      else begin
        if (m_axis_tdata !== valve_q[0]) report("valve", m_axis_tdata, valve_q[0]);
        void'(valve_q.pop_front());
      end
    end
  end

  function automatic tick_t rand_tick();
    tick_t t;
    int base;
    base = $urandom_range(4000) - 2000;
    t.sp = base;
    if ($urandom_range(9) == 0) t.pv = $urandom;
    else t.pv = base + int'($urandom_range(3000)) - 1500;
    if ($urandom_range(9) == 0) t.sp = $urandom;
    t.old = ($urandom_range(3) == 0) ? $urandom : $urandom_range(vup);
    t.chg = $urandom_range(15) == 0;
    t.want = -1;
    return t;
  endfunction

  initial begin
    tick_t dir[$];
    tick_t t;
    dir.push_back('{16'sd0, 16'sd0, 8'd0, 1'b0, 30});
    dir.push_back('{16'sh7fff, -16'sh8000, 8'd0, 1'b0, 80});
    dir.push_back('{-16'sh8000, 16'sh7fff, 8'd255, 1'b0, 0});
    dir.push_back('{16'sd1200, 16'sd0, 8'd80, 1'b1, -1});
    dir.push_back('{16'sd100, 16'sd0, 8'd255, 1'b0, -1});
    for (int i = 0; i < 10; i++) dir.push_back('{16'sd300, 16'sd0, 8'd10, 1'b0, -1});
    dir.push_back('{-16'sd3, 16'sd0, 8'd40, 1'b0, -1});
    dir.push_back('{16'sd3, 16'sd0, 8'd40, 1'b0, -1});
    dir.push_back('{16'sd3, 16'sd0, 8'd40, 1'b0, -1});
    for (int i = 0; i < 6; i++) dir.push_back('{16'sd900, 16'sd0, 8'd1, 1'b0, -1});

    reset_model();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir[i]) send(dir[i]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      if (ph == 4) begin
        write_reg(RegPropGain, 255); write_reg(RegCubicGain, 255);
        write_reg(RegIntGain, 0); write_reg(RegValveUp, 255);
        write_reg(RegValveLow, 0); write_reg(RegValveMid, 255);
        write_reg(RegRoundHyst, 127); write_reg(RegCreditMax, 127);
      end else if (ph == 6) begin
        write_reg(RegPropGain, 0); write_reg(RegCubicGain, 0);
        write_reg(RegIntGain, 255); write_reg(RegValveUp, 20);
        write_reg(RegValveLow, 60); write_reg(RegValveMid, 0);
        write_reg(RegRoundHyst, 0); write_reg(RegCreditMax, 0);
      end else if (ph != 0) begin
        for (int r = 0; r < 8; r++) write_reg(r[2:0], $urandom);
        if ($urandom_range(1)) write_reg(RegIntGain, 0);
      end
      for (int i = 0; i < 48; i++) begin
        t = rand_tick();
        send(t);
      end
      drain();
    end

    $display("Covered %0d ticks and %0d valve results over eight gain and limit settings,",
             ticks, results);
    $display("including extreme gains, crossed valve limits and stalls on both sides.");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
